/* design/ihcv_pkg.sv */
package ihcv_pkg;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_DATA    = 2'd1,
    PH_SWALLOW = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    V_OK       = 3'd0,
    V_SHORT    = 3'd1,
    V_LARGE    = 3'd2,
    V_SMALL    = 3'd3,
    V_MISMATCH = 3'd4
  } verdict_t;

  localparam int unsigned HEADER_BYTES   = 12;
  localparam int unsigned MAX_SIZE_W     = 11;
  localparam logic [10:0] MAX_SIZE_RESET = 11'd1000;
  localparam int unsigned SUM_W          = 32;
  localparam int unsigned OUT_TDATA_W    = 40;

endpackage

/* design/image_header_checksum_validator_core.sv */
// Checks image files streamed in one byte per word, tlast on the final byte of each file.
// The first twelve bytes are a header of three little-endian 32-bit words (length, width,
// checksum). The block accepts one byte every clock cycle unless stalled, with no gaps
// between files, and gives one verdict per file in the cycle after the byte that decides
// it; the remaining bytes of that file are dropped. The output register holds one result:
// a byte is accepted whenever that register is empty or is being emptied in the same
// cycle. The length times width product is formed by the multiplier while the checksum
// bytes arrive. The per-byte fold (add, 32x32 multiply, add, xor) is combinational.
module image_header_checksum_validator_core #(
  parameter int unsigned MAX_DATA_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] file_byte
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [ihcv_pkg::OUT_TDATA_W-1:0] out_tdata, // [2:0] verdict, [34:3] computed_sum
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [ihcv_pkg::MAX_SIZE_W-1:0] cfg_data    // max_size
);

  localparam int unsigned SIZE_FIELD_MAX = (1 << ihcv_pkg::MAX_SIZE_W) - 1;
  localparam int unsigned LIMIT_CAP = (MAX_DATA_BYTES < SIZE_FIELD_MAX) ?
                                      MAX_DATA_BYTES : SIZE_FIELD_MAX;
  localparam int unsigned IDX_W = $clog2(LIMIT_CAP + 1);
  localparam int unsigned SW    = ihcv_pkg::SUM_W;

  ihcv_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]       hcount_r, hcount_nxt;
  logic [SW-1:0]    hword_r [3];
  logic [SW-1:0]    size_r;
  logic [IDX_W-1:0] dsize_r, dsize_nxt;
  logic [IDX_W-1:0] didx_r, didx_nxt;
  logic [1:0]       mod3_r, mod3_nxt;
  logic [2:0]       mod5_r, mod5_nxt;
  logic [SW-1:0]    sum_r, sum_nxt;
  logic [ihcv_pkg::MAX_SIZE_W-1:0] max_size_r;

  logic             out_valid_r;
  ihcv_pkg::verdict_t out_verdict_r;
  logic [SW-1:0]    out_sum_r;

  logic             emit;
  ihcv_pkg::verdict_t emit_verdict;
  logic [SW-1:0]    emit_sum;

  logic             accept;
  logic [7:0]       byte_in;
  logic [SW-1:0]    byte_sx;
  logic [SW-1:0]    f1, f2, f3, f4;
  logic [SW-1:0]    chk_now;
  logic [IDX_W-1:0] didx_inc;
  logic [SW-1:0]    limit;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign byte_in   = in_tdata;
  assign byte_sx   = {{(SW-8){byte_in[7]}}, byte_in};

  assign limit = (SW'(max_size_r) > SW'(LIMIT_CAP)) ? SW'(LIMIT_CAP) : SW'(max_size_r);

  // The checksum word is completed by the byte being accepted on the last header byte.
  assign chk_now = {byte_in, hword_r[2][23:0]};

  // Payload fold for one byte.
  always_comb begin
    f1 = sum_r + byte_sx;
    f2 = (mod3_r != 2'd0) ? SW'(f1 * byte_sx) : f1;
    f3 = (didx_r[1:0] != 2'b00) ? f2 + byte_sx : f2;
    f4 = (mod5_r != 3'd0) ? f3 ^ byte_sx : f3;
  end

  assign didx_inc = didx_r + IDX_W'(1);

  always_comb begin
    phase_nxt    = phase_r;
    hcount_nxt   = hcount_r;
    dsize_nxt    = dsize_r;
    didx_nxt     = didx_r;
    mod3_nxt     = mod3_r;
    mod5_nxt     = mod5_r;
    sum_nxt      = sum_r;
    emit         = 1'b0;
    emit_verdict = ihcv_pkg::V_OK;
    emit_sum     = '0;
    unique case (phase_r)
      ihcv_pkg::PH_SWALLOW: begin
        if (in_tlast) begin
          phase_nxt  = ihcv_pkg::PH_HEADER;
          hcount_nxt = '0;
        end
      end
      ihcv_pkg::PH_DATA: begin
        sum_nxt  = f4;
        didx_nxt = didx_inc;
        mod3_nxt = (mod3_r >= 2'd2) ? 2'd0 : mod3_r + 2'd1;
        mod5_nxt = (mod5_r >= 3'd4) ? 3'd0 : mod5_r + 3'd1;
        if (didx_inc >= dsize_r || in_tlast) begin
          emit         = 1'b1;
          emit_sum     = f4;
          emit_verdict = (f4 == hword_r[2]) ? ihcv_pkg::V_OK : ihcv_pkg::V_MISMATCH;
          phase_nxt    = in_tlast ? ihcv_pkg::PH_HEADER : ihcv_pkg::PH_SWALLOW;
          hcount_nxt   = '0;
        end
      end
      default: begin
        hcount_nxt = hcount_r + 4'd1;
        if (hcount_nxt < 4'(ihcv_pkg::HEADER_BYTES)) begin
          if (in_tlast) begin
            emit         = 1'b1;
            emit_verdict = ihcv_pkg::V_SHORT;
            hcount_nxt   = '0;
          end
        end else begin
          hcount_nxt = '0;
          // Signed size against the limit: negative sizes count as too small.
          if (!size_r[SW-1] && size_r > limit) begin
            emit         = 1'b1;
            emit_verdict = ihcv_pkg::V_LARGE;
            phase_nxt    = in_tlast ? ihcv_pkg::PH_HEADER : ihcv_pkg::PH_SWALLOW;
          end else if (size_r[SW-1] || size_r < SW'(ihcv_pkg::HEADER_BYTES)) begin
            emit         = 1'b1;
            emit_verdict = ihcv_pkg::V_SMALL;
            phase_nxt    = in_tlast ? ihcv_pkg::PH_HEADER : ihcv_pkg::PH_SWALLOW;
          end else begin
            dsize_nxt = size_r[IDX_W-1:0];
            didx_nxt  = '0;
            mod3_nxt  = '0;
            mod5_nxt  = '0;
            sum_nxt   = '0;
            if (in_tlast) begin
              emit         = 1'b1;
              emit_sum     = '0;
              emit_verdict = (chk_now == '0) ? ihcv_pkg::V_OK : ihcv_pkg::V_MISMATCH;
              phase_nxt    = ihcv_pkg::PH_HEADER;
            end else begin
              phase_nxt = ihcv_pkg::PH_DATA;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ihcv_pkg::PH_HEADER;
      hcount_r    <= '0;
      out_valid_r <= 1'b0;
      max_size_r  <= ihcv_pkg::MAX_SIZE_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_size_r <= cfg_data;
      end
      if (accept) begin
        phase_r  <= phase_nxt;
        hcount_r <= hcount_nxt;
      end
      if (accept && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Header bytes land in place; every byte of a word is written before the word is used.
  always_ff @(posedge clk) begin
    if (accept && phase_r != ihcv_pkg::PH_DATA && phase_r != ihcv_pkg::PH_SWALLOW &&
        hcount_r[3:2] != 2'd3) begin
      hword_r[hcount_r[3:2]][8*hcount_r[1:0] +: 8] <= byte_in;
    end
  end

  // Length times width settles while the four checksum bytes arrive.
  always_ff @(posedge clk) begin
    size_r <= SW'(hword_r[0] * hword_r[1]);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dsize_r <= dsize_nxt;
      didx_r  <= didx_nxt;
      mod3_r  <= mod3_nxt;
      mod5_r  <= mod5_nxt;
      sum_r   <= sum_nxt;
    end
    if (accept && emit) begin
      out_verdict_r <= emit_verdict;
      out_sum_r     <= emit_sum;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(ihcv_pkg::OUT_TDATA_W - SW - 3)'(0), out_sum_r, out_verdict_r};

endmodule

/* tb/tb.sv */
module tb;

  localparam int DATA_CAP = 1024;

  typedef struct packed {
    logic [7:0] fb;
    logic       fin;
  } file_word_t;

  typedef struct {
    ihcv_pkg::verdict_t v;
    logic [31:0] acc;
  } verdict_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [ihcv_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ihcv_pkg::MAX_SIZE_W-1:0] cfg_data = '0;

  image_header_checksum_validator_core #(.MAX_DATA_BYTES(DATA_CAP)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  file_word_t   file_words[$];
  verdict_rec_t verdict_queue[$];
  int errors = 0;
  int bytes_queued = 0;
  int bytes_taken = 0;
  int files_queued = 0;
  int limits_written = 0;
  int verdict_hits[5] = '{default: 0};
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic in_fire_q = 1'b0;

  // Shadow of the block's parse state.
  logic [ihcv_pkg::MAX_SIZE_W-1:0] size_cap = ihcv_pkg::MAX_SIZE_RESET;
  ihcv_pkg::phase_t parse_ph = ihcv_pkg::PH_HEADER;
  int unsigned hdr_cnt = 0;
  logic [31:0] hdr_words[3] = '{default: '0};
  int unsigned pay_len = 0;
  int unsigned pay_idx = 0;
  logic [31:0] acc_sum = '0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] fold_byte(logic [31:0] acc, logic [7:0] fb,
                                            int unsigned idx);
    logic [31:0] x;
    x = {{24{fb[7]}}, fb};
    acc = acc + x;
    if (idx % 3 != 0) acc = acc * x;
    if ((idx & 3) != 0) acc = acc + x;
    if (idx % 5 != 0) acc = acc ^ x;
    return acc;
  endfunction

  task automatic restart_file();
    parse_ph = ihcv_pkg::PH_HEADER;
    hdr_cnt = 0;
    hdr_words = '{default: '0};
    pay_len = 0;
    pay_idx = 0;
    acc_sum = '0;
  endtask

  task automatic post_verdict(input ihcv_pkg::verdict_t v, input logic [31:0] acc,
                              input logic fin);
    verdict_queue.push_back('{v, acc});
    if (fin) restart_file();
    else parse_ph = ihcv_pkg::PH_SWALLOW;
  endtask

  task automatic track_file_byte(input logic [7:0] fb, input logic fin);
    logic [31:0] prod;
    int lim;
    case (parse_ph)
      ihcv_pkg::PH_SWALLOW: begin
        if (fin) restart_file();
      end
      ihcv_pkg::PH_DATA: begin
        acc_sum = fold_byte(acc_sum, fb, pay_idx);
        pay_idx++;
        if (pay_idx >= pay_len || fin)
          post_verdict(acc_sum == hdr_words[2] ? ihcv_pkg::V_OK : ihcv_pkg::V_MISMATCH,
                       acc_sum, fin);
      end
      default: begin
        hdr_words[hdr_cnt / 4][8 * (hdr_cnt % 4) +: 8] = fb;
        hdr_cnt++;
        if (hdr_cnt < ihcv_pkg::HEADER_BYTES) begin
          if (fin) post_verdict(ihcv_pkg::V_SHORT, '0, 1'b1);
        end else begin
          prod = hdr_words[0] * hdr_words[1];
          lim = (size_cap > DATA_CAP) ? DATA_CAP : int'(size_cap);
          // The size is judged as a signed number, so a product with bit 31 set is too small.
          if ($signed(prod) > lim) begin
            post_verdict(ihcv_pkg::V_LARGE, '0, fin);
          end else if ($signed(prod) < 12) begin
            post_verdict(ihcv_pkg::V_SMALL, '0, fin);
          end else begin
            pay_len = prod;
            pay_idx = 0;
            acc_sum = '0;
            if (fin)
              post_verdict(acc_sum == hdr_words[2] ? ihcv_pkg::V_OK : ihcv_pkg::V_MISMATCH,
                           acc_sum, 1'b1);
            else parse_ph = ihcv_pkg::PH_DATA;
          end
        end
      end
    endcase
  endtask

  // A fill below zero gives random payload bytes. A header kept shorter than
  // twelve bytes ends the file early.
  task automatic queue_file(input logic [31:0] len, input logic [31:0] wid, input int n_pay,
                            input bit good_sum, input int hdr_keep, input int fill);
    logic [7:0] words[$];
    logic [7:0] pay[$];
    logic [31:0] prod;
    logic [31:0] acc;
    logic [31:0] chk;
    int unsigned used;
    prod = len * wid;
    for (int i = 0; i < n_pay; i++)
      pay.push_back(fill < 0 ? 8'($urandom_range(255)) : 8'(fill));
    used = n_pay;
    if (!prod[31] && prod < used) used = prod;
    acc = '0;
    for (int i = 0; i < int'(used); i++) acc = fold_byte(acc, pay[i], i);
    chk = good_sum ? acc : ~acc;
    for (int k = 0; k < 4; k++) words.push_back(len[8 * k +: 8]);
    for (int k = 0; k < 4; k++) words.push_back(wid[8 * k +: 8]);
    for (int k = 0; k < 4; k++) words.push_back(chk[8 * k +: 8]);
    if (hdr_keep < 12) begin
      while (words.size() > hdr_keep) void'(words.pop_back());
    end else begin
      foreach (pay[i]) words.push_back(pay[i]);
    end
    foreach (words[i]) file_words.push_back('{words[i], i == words.size() - 1});
    bytes_queued += words.size();
    files_queued++;
  endtask

  task automatic queue_random_file(input int lim);
    int r;
    int sel;
    int w;
    int lo;
    int hi;
    int cap;
    int n;
    logic [31:0] len;
    logic [31:0] wid;
    r = $urandom_range(99);
    cap = lim < 48 ? lim : 48;
    if (r < 65) begin
      w = $urandom_range(1, 4);
      lo = (12 + w - 1) / w;
      hi = cap / w;
      if (hi < lo) begin
        w = 1;
        lo = 12;
        hi = cap;
      end
      len = $urandom_range(lo, hi);
      wid = w;
      n = len * wid;
      if ($urandom_range(3) == 0) begin
        len = -len;
        wid = -wid;
      end
      sel = $urandom_range(9);
      if (sel < 2) n = $urandom_range(0, n - 1);
      else if (sel < 4) n = n + $urandom_range(1, 5);
      queue_file(len, wid, n, $urandom_range(99) < 85, 12, -1);
    end else if (r < 75) begin
      queue_file($urandom, $urandom, 0, 1'b1, $urandom_range(1, 11), -1);
    end else if (r < 85) begin
      if ($urandom_range(1)) len = lim + $urandom_range(1, 300);
      else len = {1'b0, 31'($urandom)};
      queue_file(len, 1, $urandom_range(0, 4), 1'b1, 12, -1);
    end else if (r < 92) begin
      if ($urandom_range(1)) len = $urandom_range(0, 11);
      else len = -$urandom_range(1, 100);
      queue_file(len, 1, $urandom_range(0, 4), 1'b1, 12, -1);
    end else begin
      queue_file($urandom, $urandom, $urandom_range(0, 20), 1'b1, 12, -1);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (bytes_taken != bytes_queued || verdict_queue.size() != 0);
    // Swallowed words give no result, so leave time for the tail to clear.
    repeat (8) @(negedge clk);
  endtask

  task automatic write_cap(input logic [ihcv_pkg::MAX_SIZE_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    limits_written++;
  endtask

  // Driver: a new word goes out only once the previous one has been taken.
  always @(negedge clk) begin
    file_word_t nx;
    if (!in_tvalid || in_fire_q) begin
      if (rst_n && file_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nx = file_words.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= nx.fb;
        in_tlast <= nx.fin;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= $urandom_range(99) >= recv_idle_pct;
  end

  // Monitor: predict on every accepted word, then check any accepted result.
  always @(posedge clk) begin
    verdict_rec_t want;
    logic [2:0] got_v;
    logic [31:0] got_acc;
    in_fire_q <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) size_cap = cfg_data;
      if (in_tvalid && in_tready) begin
        track_file_byte(in_tdata, in_tlast);
        bytes_taken++;
      end
      if (out_tvalid && out_tready) begin
        got_v = out_tdata[2:0];
        got_acc = out_tdata[34:3];
        if (got_v <= ihcv_pkg::V_MISMATCH) verdict_hits[got_v]++;
        if (verdict_queue.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual verdict %0d sum %h",
                   $time, got_v, got_acc);
          errors++;
        end else begin
          want = verdict_queue.pop_front();
          if (got_v !== want.v) begin
            $display("%0t: verdict expected %0d actual %0d", $time, want.v, got_v);
            errors++;
          end
          if (got_acc !== want.acc) begin
            $display("%0t: computed_sum expected %h actual %h", $time, want.acc, got_acc);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    logic [ihcv_pkg::MAX_SIZE_W-1:0] caps[5];
    int start;
    int lim;
    caps = '{11'd12, 11'd1024, 11'($urandom_range(13, 1023)), 11'd40, 11'd1000};
    send_idle_pct = 34;
    recv_idle_pct = 50;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Special cases under the reset limit.
    queue_file(32'd12, 32'd1, 0, 1'b1, 1, -1);
    queue_file(32'd12, 32'd1, 0, 1'b1, 11, -1);
    queue_file(32'd2000, 32'd1, 3, 1'b1, 12, -1);
    queue_file(32'd0, 32'd5, 0, 1'b1, 12, -1);
    queue_file(32'hFFFF_FFFF, 32'd1, 2, 1'b1, 12, -1);
    queue_file(32'h8000_0000, 32'd2, 1, 1'b1, 12, -1);
    queue_file(32'd1000, 32'd1, 0, 1'b1, 12, -1);
    queue_file(32'd1001, 32'd1, 0, 1'b1, 12, -1);
    queue_file(32'd2, 32'h8000_0006, 12, 1'b1, 12, 8'hFF);
    queue_file(32'd4, 32'd3, 12, 1'b0, 12, 8'h80);
    queue_file(-32'd6, -32'd2, 15, 1'b1, 12, 8'h7F);
    queue_file(32'd20, 32'd1, 7, 1'b1, 12, 8'h00);
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      write_cap(caps[p]);
      if (p < 1) begin
        send_idle_pct = 34;
        recv_idle_pct = 50;
      end else if (p < 3) begin
        send_idle_pct = 50;
        recv_idle_pct = 34;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      lim = caps[p] > DATA_CAP ? DATA_CAP : int'(caps[p]);
      if (caps[p] == 11'd1024) begin
        // One file at the largest size the block takes, cut short, and one just past it.
        queue_file(32'd1024, 32'd1, 40, 1'b1, 12, -1);
        queue_file(32'd1025, 32'd1, 2, 1'b1, 12, -1);
      end
      start = bytes_queued;
      while (bytes_queued - start < 70) queue_random_file(lim);
      wait_drained();
    end

    $display("covered %0d files in %0d words over %0d limit writes", files_queued,
             bytes_taken, limits_written);
    $display("verdicts ok %0d, short %0d, large %0d, small %0d, mismatch %0d",
             verdict_hits[ihcv_pkg::V_OK], verdict_hits[ihcv_pkg::V_SHORT],
             verdict_hits[ihcv_pkg::V_LARGE], verdict_hits[ihcv_pkg::V_SMALL],
             verdict_hits[ihcv_pkg::V_MISMATCH]);
    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: errors");
    $finish;
  end

endmodule
